// File: hdl/tensor_element_to_fp32_macros.svh
// Assertion macros for the tensor element converter.
// No dependencies; included by files that carry assertions.
`ifndef TENSOR_ELEMENT_TO_FP32_MACROS_SVH
`define TENSOR_ELEMENT_TO_FP32_MACROS_SVH
`ifndef SYNTHESIS
`define TEF_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TEF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TEF_ASSERT_IMP(label, clk, rstn, ante, cons)
`define TEF_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// File: hdl/tef_pkg.sv
// Shared types and constants for the tensor element converter.
// No dependencies.
package tef_pkg;
    localparam int unsigned QueueDepth = 2;

    typedef enum logic [3:0] {
        TYPE_F32  = 4'd0,
        TYPE_F16  = 4'd1,
        TYPE_BF16 = 4'd2,
        TYPE_I64  = 4'd3,
        TYPE_I32  = 4'd4,
        TYPE_U8   = 4'd5,
        TYPE_BOOL = 4'd6,
        TYPE_C64  = 4'd7
    } elem_type_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOIMP = 2'd1,
        ST_UNSUP = 2'd2
    } status_t;

    // class of work the back end must do
    typedef enum logic [1:0] {
        OP_PASS = 2'd0,   // bits already final
        OP_HALF = 2'd1,   // half to single
        OP_INT  = 2'd2    // integer magnitude round
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        neg;
        logic [63:0] mag;
        logic [1:0]  status;
    } work_t;

    localparam logic [1:0] AddrElemType = 2'd0;
endpackage

// File: hdl/tef_front.sv
// Front end: classifies a word by element type and forms the work record.
// Depends on tef_pkg.
module tef_front (
    input  logic [3:0]           element_type,
    input  logic [63:0]          raw_bits,
    output tef_pkg::work_t       work
);
    logic [63:0] x32;
    always_comb begin
        x32 = {32'd0, raw_bits[31:0]};
        work = '{op: tef_pkg::OP_PASS, neg: 1'b0, mag: 64'd0, status: tef_pkg::ST_OK};
        case (element_type)
            tef_pkg::TYPE_F32:  work.mag = x32;
            tef_pkg::TYPE_F16: begin
                work.op  = tef_pkg::OP_HALF;
                work.mag = {48'd0, raw_bits[15:0]};
            end
            tef_pkg::TYPE_BF16: work.mag = {32'd0, raw_bits[15:0], 16'd0};
            tef_pkg::TYPE_I64: begin
                work.op  = tef_pkg::OP_INT;
                work.neg = raw_bits[63];
                work.mag = raw_bits[63] ? (~raw_bits + 64'd1) : raw_bits;
            end
            tef_pkg::TYPE_I32: begin
                work.op  = tef_pkg::OP_INT;
                work.neg = raw_bits[31];
                work.mag = raw_bits[31] ? {32'd0, ~raw_bits[31:0] + 32'd1} : x32;
            end
            tef_pkg::TYPE_U8, tef_pkg::TYPE_BOOL: begin
                work.op  = tef_pkg::OP_INT;
                work.mag = {56'd0, raw_bits[7:0]};
            end
            tef_pkg::TYPE_C64: work.status = tef_pkg::ST_NOIMP;
            default:           work.status = tef_pkg::ST_UNSUP;
        endcase
    end
endmodule

// File: hdl/tef_queue.sv
// Small FIFO of work records between front and back ends.
// Depends on tef_pkg and the macros header.
`include "tensor_element_to_fp32_macros.svh"
module tef_queue #(
    parameter int unsigned DEPTH = tef_pkg::QueueDepth
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  tef_pkg::work_t in_work,
    output logic           out_valid,
    input  logic           out_ready,
    output tef_pkg::work_t out_work
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    tef_pkg::work_t mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic push, pop;

    assign in_ready  = (cnt_reg != AW'(0) + (AW+1)'(DEPTH)) || out_ready;
    assign out_valid = cnt_reg != '0;
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;
    assign out_work = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wp_reg] <= in_work;
        end
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    `TEF_ASSERT_IMP(a_no_over, aclk, aresetn, 1'b1, cnt_reg <= (AW+1)'(DEPTH))
    `TEF_ASSERT_NEXT(a_cnt_up, aclk, aresetn, push && !pop, cnt_reg == $past(cnt_reg) + 1'b1)
    `TEF_ASSERT_NEXT(a_cnt_dn, aclk, aresetn, pop && !push, cnt_reg == $past(cnt_reg) - 1'b1)
endmodule

// File: hdl/tef_back.sv
// Back end: two-stage conversion (normalize, then round and pack).
// Depends on tef_pkg.
module tef_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  tef_pkg::work_t in_work,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [31:0]    float_bits,
    output logic [1:0]     status
);
    // stage 1: leading-one position and left-aligned magnitude
    logic        s1_v_reg, s2_v_reg;
    logic        s1_ready, s2_ready;
    tef_pkg::op_t s1_op_reg;
    logic        s1_neg_reg, s1_zero_reg;
    logic [5:0]  s1_p_reg;
    logic [63:0] s1_norm_reg;
    logic [1:0]  s1_st_reg;
    logic [5:0]  p_next;
    logic [63:0] norm_next;
    logic [31:0] float_bits_reg;
    logic [1:0]  status_reg;

    assign s2_ready = !s2_v_reg || out_ready;
    assign s1_ready = !s1_v_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb begin
        p_next = '0;
        for (int i = 0; i < 64; i++) begin
            if (in_work.mag[i]) begin
                p_next = 6'(i);
            end
        end
        norm_next = in_work.mag << (6'd63 - p_next);
    end

    always_ff @(posedge aclk) begin
        if (s1_ready && in_valid) begin
            s1_op_reg   <= in_work.op;
            s1_neg_reg  <= in_work.neg;
            s1_zero_reg <= in_work.mag == 64'd0;
            s1_p_reg    <= p_next;
            s1_norm_reg <= (in_work.op == tef_pkg::OP_INT) ? norm_next : in_work.mag;
            s1_st_reg   <= in_work.status;
        end
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_v_reg <= in_valid;
        end
    end

    // stage 2: round / pack
    logic [31:0] bits_c;
    logic [23:0] keep;
    logic        lsb, rnd, stk;
    logic [24:0] keep_r;
    logic [15:0] h;
    logic [4:0]  he;
    logic [9:0]  hm, hn;
    logic [3:0]  lz;
    always_comb begin
        keep   = s1_norm_reg[63:40];
        lsb    = keep[0];
        rnd    = s1_norm_reg[39];
        stk    = |s1_norm_reg[38:0];
        keep_r = {1'b0, keep} + 25'(rnd && (stk || lsb));
        h  = s1_norm_reg[15:0];
        he = h[14:10];
        hm = h[9:0];
        lz = '0;
        for (int i = 0; i < 10; i++) begin
            if (hm[i]) begin
                lz = 4'(9 - i);
            end
        end
        hn = 10'(hm << (lz + 4'd1));
        case (s1_op_reg)
            tef_pkg::OP_HALF: begin
                if (he == 5'd0) begin
                    bits_c = (hm == 10'd0) ? {h[15], 31'd0}
                           : {h[15], 8'(8'd112 - 8'(lz)), hn, 13'd0};
                end else if (he == 5'd31) begin
                    bits_c = {h[15], 8'hFF, hm, 13'd0};
                end else begin
                    bits_c = {h[15], 8'(8'(he) + 8'd112), hm, 13'd0};
                end
            end
            tef_pkg::OP_INT: begin
                bits_c = s1_zero_reg ? 32'd0
                       : {s1_neg_reg, 31'((32'(s1_p_reg) + 32'd127) << 23)
                                      + 31'(keep_r - 25'h800000)};
            end
            default: bits_c = s1_norm_reg[31:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s2_ready && s1_v_reg) begin
            float_bits_reg <= bits_c;
            status_reg     <= s1_st_reg;
        end
        if (!aresetn) begin
            s2_v_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_v_reg <= s1_v_reg;
        end
    end
    assign out_valid  = s2_v_reg;
    assign float_bits = float_bits_reg;
    assign status     = status_reg;
endmodule

// File: hdl/tensor_element_to_fp32.sv
// Top level of the tensor element to binary32 converter.
// Depends on tef_pkg, tef_front, tef_queue, tef_back, macros header.
//
//  channel | ports                      | role
//  s_      | s_valid/s_ready, raw_bits  | input word (raw element)
//  m_      | m_valid/m_ready, float,st  | result word
//  apb     | psel..prdata               | element_type register at 0x0
//
// One word per cycle sustained while m_ready stays high; the path is registered
// in the queue, the normalize stage and the pack stage. The front classifies combinationally into a 2-entry
// queue; the back is a two-stage pipeline with its own stall chain.
// aresetn is synchronous, active low; it clears element_type to F32.
// Either side may stall; the queue lets the front keep accepting.
`include "tensor_element_to_fp32_macros.svh"
module tensor_element_to_fp32 #(
    parameter int unsigned QUEUE_DEPTH = tef_pkg::QueueDepth
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_raw_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_float_bits,
    output logic [1:0]  m_status
);
    logic [3:0] element_type_reg;
    tef_pkg::work_t f_work, q_work;
    logic q_valid, q_ready;

    assign pready = 1'b1;
    assign prdata = (paddr == tef_pkg::AddrElemType) ? {28'd0, element_type_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            element_type_reg <= tef_pkg::TYPE_F32;
        end else if (psel && penable && pwrite && paddr == tef_pkg::AddrElemType) begin
            element_type_reg <= pwdata[3:0];
        end
    end

    tef_front u_front (
        .element_type(element_type_reg),
        .raw_bits    (s_raw_bits),
        .work        (f_work)
    );

    tef_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk, .aresetn,
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_work  (f_work),
        .out_valid(q_valid),
        .out_ready(q_ready),
        .out_work (q_work)
    );

    tef_back u_back (
        .aclk, .aresetn,
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_work   (q_work),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .float_bits(m_float_bits),
        .status    (m_status)
    );

    `TEF_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_float_bits))
    `TEF_ASSERT_IMP(a_st_range, aclk, aresetn, m_valid, m_status != 2'd3)
    `TEF_ASSERT_IMP(a_err_zero, aclk, aresetn, m_valid && m_status != tef_pkg::ST_OK, m_float_bits == 32'd0)
endmodule

// File: test/tensor_element_to_fp32_tb.sv
// Testbench for tensor_element_to_fp32: raw elements in, binary32 words out.
// Depends on tef_pkg and the RTL; a scoreboard class predicts each result.

class fp32_scoreboard;
    logic [31:0] want_bits[$];
    logic [1:0]  want_status[$];
    logic [3:0]  etype;
    int          errors;

    function new();
        etype = 4'd0;
        errors = 0;
    endfunction

    // magnitude to binary32, round to nearest even
    function logic [31:0] round_mag(logic neg, logic [63:0] mag);
        int          msb;
        int          sh;
        logic [63:0] keep;
        logic [63:0] rem;
        logic [63:0] half;
        logic [31:0] r;
        if (mag == 64'd0) begin
            return 32'd0;
        end
        msb = 0;
        for (int i = 0; i < 64; i++) begin
            if (mag[i]) begin
                msb = i;
            end
        end
        if (msb <= 23) begin
            keep = mag << (23 - msb);
        end else begin
            sh = msb - 23;
            rem = mag & ((64'd1 << sh) - 64'd1);
            half = 64'd1 << (sh - 1);
            keep = mag >> sh;
            if (rem > half || (rem == half && keep[0])) begin
                keep = keep + 64'd1;
            end
        end
        r = ((msb + 127) << 23) + (keep[31:0] - 32'h0080_0000);
        return {neg, 31'd0} + r;
    endfunction

    function logic [31:0] widen_half(logic [15:0] h);
        logic [4:0] e;
        logic [10:0] m;
        int          ex;
        e = h[14:10];
        m = {1'b0, h[9:0]};
        if (e == 5'd0) begin
            if (m == 11'd0) begin
                return {h[15], 31'd0};
            end
            ex = 1;
            while (!m[10]) begin
                m = m << 1;
                ex--;
            end
            return {h[15], 8'(ex + 112), m[9:0], 13'd0};
        end
        if (e == 5'd31) begin
            return {h[15], 8'hFF, h[9:0], 13'd0};
        end
        return {h[15], 8'(e + 112), h[9:0], 13'd0};
    endfunction

    // note an accepted input word
    function void note_element(logic [63:0] x);
        logic [31:0] b;
        logic [1:0]  st;
        b = 32'd0;
        st = tef_pkg::ST_OK;
        case (etype)
            tef_pkg::TYPE_F32:  b = x[31:0];
            tef_pkg::TYPE_F16:  b = widen_half(x[15:0]);
            tef_pkg::TYPE_BF16: b = {x[15:0], 16'd0};
            tef_pkg::TYPE_I64:  b = round_mag(x[63], x[63] ? -x : x);
            tef_pkg::TYPE_I32:  b = round_mag(x[31], {32'd0, x[31] ? -x[31:0] : x[31:0]});
            tef_pkg::TYPE_U8, tef_pkg::TYPE_BOOL: b = round_mag(1'b0, {56'd0, x[7:0]});
            tef_pkg::TYPE_C64:  st = tef_pkg::ST_NOIMP;
            default:            st = tef_pkg::ST_UNSUP;
        endcase
        want_bits.push_back(b);
        want_status.push_back(st);
    endfunction

    function void check_result(logic [31:0] bits, logic [1:0] st);
        logic [31:0] eb;
        logic [1:0]  es;
        if (want_bits.size() == 0) begin
            errors++;
            if (errors <= 10) begin
                $display("unexpected word: bits %h status %0d", bits, st);
            end
            return;
        end
        eb = want_bits.pop_front();
        es = want_status.pop_front();
        if (eb !== bits || es !== st) begin
            errors++;
            if (errors <= 10) begin
                $display("mismatch: expected %h/%0d got %h/%0d", eb, es, bits, st);
            end
        end
    endfunction
endclass

module tensor_element_to_fp32_tb;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_raw_bits;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_float_bits;
    logic [1:0]  m_status;

    fp32_scoreboard board;
    int  send_idle;   // percent of cycles the sender holds back
    int  recv_stall;  // percent of cycles the receiver stalls

    tensor_element_to_fp32 dut (.*);

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // receiver: random stall, check every accepted word
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_result(m_float_bits, m_status);
        end
        m_ready <= ($urandom_range(99) >= recv_stall);
    end

    // register write: setup then access cycle
    task automatic write_type(logic [3:0] t);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= tef_pkg::AddrElemType;
        pwdata  <= {8'($urandom_range(255, 0)), 20'd0, t};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.etype = t;
    endtask

    // wait for all results, then let the pipe settle
    task automatic drain();
        while (board.want_bits.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // send one word; valid stays up back to back
    task automatic send_word(logic [63:0] x);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_raw_bits <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_element(x);
    endtask

    task automatic idle_sender();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // random element shaped by type so edges get hit
    function automatic logic [63:0] pick_element(logic [3:0] t);
        logic [63:0] x;
        x = {$urandom, $urandom};
        case ($urandom_range(5))
            0: x = x & 64'hFF;
            1: x = x >> $urandom_range(63);
            2: x = -(x >> $urandom_range(63));
            3: if (t == tef_pkg::TYPE_F16) x[14:10] = $urandom_range(1) ? 5'd0 : 5'd31;
            4: x[31:0] = {$urandom_range(1) ? 8'hFF : 8'h80, 24'd0} | (x[31:0] >> 8);
            default: ;
        endcase
        return x;
    endfunction

    initial begin
        #6_000_000;
        $display("tensor_element_to_fp32_tb NOT OK");
        $finish;
    end

    initial begin
        logic [63:0] edge_vals[$];
        logic [3:0]  t;

        board = new();
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_valid = 1'b0; s_raw_bits = '0; m_ready = 1'b0;
        send_idle = 0; recv_stall = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, half subnormal/inf/NaN, min ints, ties
        edge_vals = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                      64'h7FFF_FFFF_FFFF_FFFF, 64'h0000_0000_8000_0000,
                      64'h0000_0000_7FFF_FFFF, 64'h0000_0001, 64'h03FF, 64'h7C00,
                      64'hFC00, 64'h7C01, 64'h8001, 64'h0100_0001, 64'h0100_0003,
                      64'hABCD_0000_0000_00FE, 64'h0000_0000_00FF_FFFF};
        for (int k = 0; k < 16; k++) begin
            if (k == 9) begin
                for (int j = 0; j < 10; j++) send_word(edge_vals[j]);
            end
        end
        for (int ty = 0; ty < 16; ty += (ty < 9 ? 1 : 6)) begin
            idle_sender();
            drain();
            write_type(ty[3:0]);
            foreach (edge_vals[j]) begin
                if (j < 3 || ty <= 6 || j == 5) send_word(edge_vals[j]);
            end
        end

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 12; ph++) begin
            send_idle  = (ph % 4 == 1) ? 87 : (ph % 4 == 3) ? 37 : 0;
            recv_stall = (ph % 4 == 2) ? 87 : (ph % 4 == 3) ? 37 : 0;
            idle_sender();
            drain();
            t = (ph == 11) ? 4'd15 : 4'($urandom_range(8));
            if ($urandom_range(9) == 0) t = 4'($urandom_range(15, 9));
            write_type(t);
            for (int i = 0; i < 100; i++) begin
                send_word(pick_element(t));
                if (ph == 5 && i == 50) begin
                    idle_sender();
                    while (board.want_bits.size() != 0) @(posedge aclk);
                end
            end
        end

        idle_sender();
        drain();
        if (board.errors == 0 && board.want_bits.size() == 0) begin
            $display("tensor_element_to_fp32_tb OK");
        end else begin
            $display("tensor_element_to_fp32_tb NOT OK");
        end
        $finish;
    end
endmodule
